@@ src/prts_pkg.sv @@
`default_nettype none

package prts_pkg;

  // table sizes
  localparam int MAX_TASKS   = 32;
  localparam int PRIO_LEVELS = 8;
  localparam int SLOT_W      = $clog2(MAX_TASKS);
  localparam int PRIO_W      = $clog2(PRIO_LEVELS);
  localparam int CNT_W       = $clog2(MAX_TASKS + 1);

  // actions of one input transaction
  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_CREATE  = 3'd1,
    ACT_DESTROY = 3'd2,
    ACT_YIELD   = 3'd3,
    ACT_BLOCK   = 3'd4,
    ACT_UNBLOCK = 3'd5,
    ACT_SETPRIO = 3'd6,
    ACT_NONE    = 3'd7
  } act_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_PRIO   = 2'd1,
    STAT_NOTASK = 2'd2,
    STAT_FULL   = 2'd3
  } stat_e;

  // task states
  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_RUNNING = 2'd1,
    TS_BLOCKED = 2'd2
  } tstate_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] task_id;
    logic [2:0]  priority_req;
    logic [31:0] wakeup_tick;
  } prts_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] new_task_id;
    logic [31:0] running_task_id;
    logic        running_valid;
    logic        switched;
    logic        preempted;
  } prts_out_t;

endpackage

`default_nettype wire

@@ src/priority_round_robin_task_scheduler.sv @@
`default_nettype none

// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o    prts_in_t  in_data_i
// out       output     out_valid_o / out_ready_i  prts_out_t out_data_o
// cfg       input      cfg_valid_i / cfg_ready_o  quantum_ticks cfg_data_i
//
// One transaction runs through a sequencer that visits one task slot a cycle.
// tick: a wake scan, a quantum check when a task runs, a head search when it is
// preempted, then the result is posted. create, unblock: one slot scan; destroy:
// a find scan and a delete step; yield, block: requeue or block the running task,
// then a head search; set priority: the result is posted directly.
// Asynchronous active-low reset; the slot table needs no clearing pass.
// in_ready_o is high only in idle; a result held by out_ready_i low stalls
// the posting cycle, while the next transaction may already be taken.
module priority_round_robin_task_scheduler
  import prts_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire prts_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output prts_out_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_WAKE   = 11'b00000000010,
    ST_RUNCHK = 11'b00000000100,
    ST_REQ    = 11'b00000001000,
    ST_BLK    = 11'b00000010000,
    ST_DISP   = 11'b00000100000,
    ST_FREE   = 11'b00001000000,
    ST_FIND   = 11'b00010000000,
    ST_DEL    = 11'b00100000000,
    ST_UNBLK  = 11'b01000000000,
    ST_DONE   = 11'b10000000000
  } st_e;

  // control state
  st_e                st_q, st_d;
  logic [SLOT_W-1:0]  scan_q, scan_d;
  logic [MAX_TASKS-1:0] used_q;
  logic [CNT_W-1:0]   cnt_q [PRIO_LEVELS];
  logic               run_flag_q;
  logic [SLOT_W-1:0]  run_slot_q;
  logic [31:0]        next_id_q;
  logic [31:0]        tick_q;
  logic [7:0]         quant_q;
  logic               out_valid_q;

  // slot table and working registers
  tstate_e            tst_q   [MAX_TASKS];
  logic [31:0]        id_q    [MAX_TASKS];
  logic [PRIO_W-1:0]  prio_q  [MAX_TASKS];
  logic [7:0]         slice_q [MAX_TASKS];
  logic [31:0]        wake_q  [MAX_TASKS];
  logic [SLOT_W-1:0]  pos_q   [MAX_TASKS];
  prts_in_t           cap_q;
  stat_e              status_q;
  logic [31:0]        new_id_q;
  logic               pre_q;
  logic               old_flag_q;
  logic [SLOT_W-1:0]  old_slot_q;
  logic [31:0]        run_id_q;
  logic               found_q;
  logic [PRIO_W+SLOT_W-1:0] best_key_q;
  logic [SLOT_W-1:0]  best_slot_q;
  prts_out_t          out_q;

  // combinational
  logic               acc, last, out_load;
  logic [SLOT_W-1:0]  rd_idx;
  logic               r_used;
  tstate_e            r_tst;
  logic [31:0]        r_id, r_wake;
  logic [PRIO_W-1:0]  r_prio, hl_lv, push_lv, dec_lv;
  logic [7:0]         r_slice;
  logic [SLOT_W-1:0]  r_pos, dec_pos;
  logic               hl_any;
  logic               hit_wake, hit_head, hit_free, hit_find, hit_unblk, do_pre;
  logic               push_en, dec_en;
  logic [31:0]        nid;
  logic               prio_bad;
  logic [CNT_W+PRIO_W-1:0] cnt_total;

  assign in_ready_o  = (st_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign acc         = in_valid_i && in_ready_o;
  assign last        = (scan_q == SLOT_W'(MAX_TASKS - 1));
  assign out_load    = (st_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign nid         = (next_id_q == 32'd0) ? 32'd1 : next_id_q;
  assign prio_bad    = {1'b0, in_data_i.priority_req} >= 4'(PRIO_LEVELS);

  // single slot read port
  assign rd_idx  = (st_q == ST_RUNCHK || st_q == ST_REQ || st_q == ST_BLK) ?
                   run_slot_q : scan_q;
  assign r_used  = used_q[rd_idx];
  assign r_tst   = tst_q[rd_idx];
  assign r_id    = id_q[rd_idx];
  assign r_prio  = prio_q[rd_idx];
  assign r_slice = slice_q[rd_idx];
  assign r_wake  = wake_q[rd_idx];
  assign r_pos   = pos_q[rd_idx];

  // highest non-empty ready queue
  always_comb begin
    hl_any = 1'b0;
    hl_lv  = '0;
    for (int l = 0; l < PRIO_LEVELS; l++) begin
      if (cnt_q[l] != '0) begin
        hl_any = 1'b1;
        hl_lv  = PRIO_W'(l);
      end
    end
  end

  // per-slot tests of the scan unit
  assign hit_wake  = r_used && (r_tst == TS_BLOCKED) && (r_wake != 32'd0) &&
                     (tick_q >= r_wake);
  assign hit_head  = r_used && (r_tst == TS_READY) && (r_prio == hl_lv) &&
                     (r_pos == '0);
  assign hit_free  = !r_used;
  assign hit_find  = r_used && (r_tst == TS_READY) && (r_id == cap_q.task_id) &&
                     (!found_q || ({r_prio, r_pos} < best_key_q));
  assign hit_unblk = r_used && (r_tst == TS_BLOCKED) && (r_id == cap_q.task_id);
  assign do_pre    = (r_slice <= 8'd1) || (hl_any && (hl_lv > r_prio));

  // queue push and removal controls
  assign push_en = ((st_q == ST_WAKE) && hit_wake) ||
                   ((st_q == ST_RUNCHK) && do_pre) ||
                   (st_q == ST_REQ) ||
                   ((st_q == ST_FREE) && hit_free) ||
                   ((st_q == ST_UNBLK) && hit_unblk);
  assign push_lv = (st_q == ST_FREE) ? PRIO_W'(cap_q.priority_req) : r_prio;

  always_comb begin
    dec_en  = 1'b0;
    dec_lv  = hl_lv;
    dec_pos = '0;
    if (st_q == ST_DISP && hl_any && hit_head) begin
      dec_en = 1'b1;
    end else if (st_q == ST_DEL && found_q) begin
      dec_en  = 1'b1;
      dec_lv  = best_key_q[PRIO_W+SLOT_W-1:SLOT_W];
      dec_pos = best_key_q[SLOT_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    st_d   = st_q;
    scan_d = scan_q + SLOT_W'(1);
    case (st_q)
      ST_IDLE: begin
        scan_d = '0;
        if (acc) begin
          case (act_e'(in_data_i.action))
            ACT_TICK:    st_d = ST_WAKE;
            ACT_CREATE:  st_d = prio_bad ? ST_DONE : ST_FREE;
            ACT_DESTROY: st_d = ST_FIND;
            ACT_YIELD:   st_d = run_flag_q ? ST_REQ : ST_DISP;
            ACT_BLOCK:   st_d = run_flag_q ? ST_BLK : ST_DONE;
            ACT_UNBLOCK: st_d = ST_UNBLK;
            default:     st_d = ST_DONE;
          endcase
        end
      end
      ST_WAKE: if (last) st_d = run_flag_q ? ST_RUNCHK : ST_DONE;
      ST_RUNCHK: begin
        scan_d = '0;
        st_d   = do_pre ? ST_DISP : ST_DONE;
      end
      ST_REQ: begin
        scan_d = '0;
        st_d   = ST_DISP;
      end
      ST_BLK: begin
        scan_d = '0;
        st_d   = ST_DISP;
      end
      ST_DISP:  if (!hl_any || hit_head || last) st_d = ST_DONE;
      ST_FREE:  if (hit_free || last) st_d = ST_DONE;
      ST_FIND:  if (last) st_d = ST_DEL;
      ST_DEL:   st_d = ST_DONE;
      ST_UNBLK: if (hit_unblk || last) st_d = ST_DONE;
      ST_DONE:  if (out_load) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      scan_q      <= '0;
      used_q      <= '0;
      run_flag_q  <= 1'b0;
      run_slot_q  <= '0;
      next_id_q   <= 32'd1;
      tick_q      <= '0;
      quant_q     <= 8'd10;
      out_valid_q <= 1'b0;
      for (int l = 0; l < PRIO_LEVELS; l++) cnt_q[l] <= '0;
    end else begin
      st_q   <= st_d;
      scan_q <= scan_d;
      if (cfg_valid_i) quant_q <= cfg_data_i;
      if (acc && act_e'(in_data_i.action) == ACT_TICK) tick_q <= tick_q + 32'd1;
      // queue lengths
      for (int l = 0; l < PRIO_LEVELS; l++) begin
        if (push_en && push_lv == PRIO_W'(l)) cnt_q[l] <= cnt_q[l] + CNT_W'(1);
        if (dec_en && dec_lv == PRIO_W'(l))   cnt_q[l] <= cnt_q[l] - CNT_W'(1);
      end
      // slot allocation
      if (st_q == ST_FREE && hit_free) begin
        used_q[rd_idx] <= 1'b1;
        next_id_q      <= nid + 32'd1;
      end
      if (st_q == ST_DEL && found_q) used_q[best_slot_q] <= 1'b0;
      // running task
      if ((st_q == ST_RUNCHK && do_pre) || st_q == ST_REQ || st_q == ST_BLK)
        run_flag_q <= 1'b0;
      if (st_q == ST_DISP && hl_any && hit_head) begin
        run_flag_q <= 1'b1;
        run_slot_q <= rd_idx;
      end
      // result handshake
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // slot table and datapath
  always_ff @(posedge clk_i) begin
    if (acc) begin
      cap_q      <= in_data_i;
      status_q   <= STAT_OK;
      new_id_q   <= '0;
      pre_q      <= 1'b0;
      found_q    <= 1'b0;
      old_flag_q <= run_flag_q;
      old_slot_q <= run_slot_q;
      if (act_e'(in_data_i.action) == ACT_CREATE && prio_bad) status_q <= STAT_PRIO;
      if (act_e'(in_data_i.action) == ACT_SETPRIO) begin
        if (prio_bad) status_q <= STAT_PRIO;
        else if (!run_flag_q || run_id_q != in_data_i.task_id) status_q <= STAT_NOTASK;
        else prio_q[run_slot_q] <= PRIO_W'(in_data_i.priority_req);
      end
    end
    // close the gap behind a removed queue entry
    if (dec_en) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        if (used_q[i] && tst_q[i] == TS_READY && prio_q[i] == dec_lv &&
            pos_q[i] > dec_pos)
          pos_q[i] <= pos_q[i] - SLOT_W'(1);
      end
    end
    // per-state slot updates
    case (st_q)
      ST_WAKE: if (hit_wake) wake_q[rd_idx] <= '0;
      ST_RUNCHK: begin
        if (do_pre) begin
          slice_q[rd_idx] <= quant_q;
          pre_q           <= 1'b1;
        end else if (r_slice != 8'd0) begin
          slice_q[rd_idx] <= r_slice - 8'd1;
        end
      end
      ST_REQ: slice_q[rd_idx] <= quant_q;
      ST_BLK: begin
        tst_q[rd_idx]  <= TS_BLOCKED;
        wake_q[rd_idx] <= cap_q.wakeup_tick;
      end
      ST_DISP: begin
        if (hl_any && hit_head) begin
          tst_q[rd_idx] <= TS_RUNNING;
          run_id_q      <= r_id;
        end
      end
      ST_FREE: begin
        if (hit_free) begin
          id_q[rd_idx]    <= nid;
          prio_q[rd_idx]  <= PRIO_W'(cap_q.priority_req);
          slice_q[rd_idx] <= quant_q;
          wake_q[rd_idx]  <= '0;
          new_id_q        <= nid;
        end else if (last) begin
          status_q <= STAT_FULL;
        end
      end
      ST_FIND: begin
        if (hit_find) begin
          found_q     <= 1'b1;
          best_key_q  <= {r_prio, r_pos};
          best_slot_q <= rd_idx;
        end
      end
      ST_DEL: if (!found_q) status_q <= STAT_NOTASK;
      ST_UNBLK: begin
        if (hit_unblk) wake_q[rd_idx] <= '0;
        else if (last) status_q <= STAT_NOTASK;
      end
      default: ;
    endcase
    // tail of a ready queue
    if (push_en) begin
      pos_q[rd_idx] <= cnt_q[push_lv][SLOT_W-1:0];
      tst_q[rd_idx] <= TS_READY;
    end
    // result
    if (out_load) begin
      out_q.status          <= status_q;
      out_q.new_task_id     <= new_id_q;
      out_q.running_task_id <= run_flag_q ? run_id_q : 32'd0;
      out_q.running_valid   <= run_flag_q;
      out_q.switched        <= (run_flag_q != old_flag_q) ||
                               (run_flag_q && run_slot_q != old_slot_q);
      out_q.preempted       <= pre_q;
    end
  end

  // total of ready queue lengths
  always_comb begin
    cnt_total = '0;
    for (int l = 0; l < PRIO_LEVELS; l++)
      cnt_total = cnt_total + (CNT_W+PRIO_W)'(cnt_q[l]);
  end

  // checks
  a_idle_out_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.running_valid |-> out_data_o.running_task_id == 32'd0)
    else $error("idle result carries a task id");

  a_queue_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_total <= (CNT_W+PRIO_W)'(MAX_TASKS))
    else $error("ready queues hold more entries than slots");

  a_disp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_DISP |-> !run_flag_q)
    else $error("dispatch with a task still running");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> !in_ready_o)
    else $error("new transaction taken while one is in work");

endmodule

`default_nettype wire
